### sv/actr_pkg.sv
`default_nettype none
package actr_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CountW     = 5;
  localparam int unsigned RkRows     = 15;   // 128-bit round keys
  localparam int unsigned RkRowW     = 4;
  localparam int unsigned RkIdxW     = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_RND,
    ST_OUT
  } state_t;

  localparam logic [2:0] CfgMode  = 3'd0;
  localparam logic [2:0] CfgKey0  = 3'd1;
  localparam logic [2:0] CfgKey1  = 3'd2;
  localparam logic [2:0] CfgKey2  = 3'd3;
  localparam logic [2:0] CfgKey3  = 3'd4;
  localparam logic [2:0] CfgNonce = 3'd5;

  localparam logic [1:0] Mode128 = 2'd0;
  localparam logic [1:0] Mode256 = 2'd2;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

### sv/actr_if.sv
`default_nettype none
interface actr_if #(
  parameter int unsigned PayloadW = 8
) (
  input wire logic clk
);
  logic                valid;
  logic                ready;
  logic [PayloadW-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/actr_round.sv
`default_nettype none
// one aes round on a 128-bit state, bytes little-endian in the vector
module actr_round (
  input  wire logic [127:0] state_i,
  input  wire logic         final_i,
  input  wire logic [127:0] rkey_i,
  output logic      [127:0] state_o
);
  logic [7:0] s  [16];
  logic [7:0] t  [16];
  logic [7:0] m  [16];

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int i = 0; i < 16; i++) s[i] = state_i[8*i +: 8];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4*c] = actr_pkg::sbox(s[r + 4*((c + r) % 4)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ al ^ actr_pkg::xtime(a0 ^ a1);
      m[4*c+1] = a1 ^ al ^ actr_pkg::xtime(a1 ^ a2);
      m[4*c+2] = a2 ^ al ^ actr_pkg::xtime(a2 ^ a3);
      m[4*c+3] = a3 ^ al ^ actr_pkg::xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      state_o[8*i +: 8] = (final_i ? t[i] : m[i]) ^ rkey_i[8*i +: 8];
    end
  end
endmodule
`default_nettype wire

### sv/aes_ctr_byte_offset_cipher.sv
`default_nettype none
// channel | payload                                                   | dir
// in_     | begin_req start_offset data_lo data_hi byte_count last_in | sink
// out_    | out_lo out_hi out_count last_out                          | source
// cfg_    | cfg_we cfg_index cfg_data                                 | write only
//
// sequence: key schedule one 32-bit word a cycle (40/46/52 words for aes-128/192/256),
// then the initial whitening, one round a cycle (10/12/14), then the result is formed
// a new request is accepted once the result has moved into the output register
// rst_n is synchronous; it clears config, state, offset and the valid flag
// in_ready is high only when idle; a result still waiting holds the next
// request in its output step until the sink takes it
module aes_ctr_byte_offset_cipher (
  input  wire logic  clk,
  input  wire logic  rst_n,
  actr_if.sink       in_ch,
  actr_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int unsigned IdxW = actr_pkg::RkIdxW;

  // in payload: {begin_req, start_offset, data_lo, data_hi, byte_count, last_in}
  logic        in_begin_req;
  logic [63:0] in_start_offset, in_data_lo, in_data_hi;
  logic [4:0]  in_byte_count;
  logic        in_last_in;
  assign {in_begin_req, in_start_offset, in_data_lo, in_data_hi,
          in_byte_count, in_last_in} = in_ch.payload;

  // config registers
  logic [1:0]  mode_r;
  logic [63:0] key_r [4];
  logic [63:0] nonce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      key_r   <= '{default: '0};
      nonce_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        actr_pkg::CfgMode:  mode_r   <= cfg_data[1:0];
        actr_pkg::CfgKey0:  key_r[0] <= cfg_data;
        actr_pkg::CfgKey1:  key_r[1] <= cfg_data;
        actr_pkg::CfgKey2:  key_r[2] <= cfg_data;
        actr_pkg::CfgKey3:  key_r[3] <= cfg_data;
        actr_pkg::CfgNonce: nonce_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // key length decode; unused codes 1 and 3 act as aes-192
  logic [3:0] nk;
  logic [3:0] nr;
  always_comb begin
    nk = (mode_r == actr_pkg::Mode128) ? 4'd4 :
         (mode_r == actr_pkg::Mode256) ? 4'd8 : 4'd6;
    nr = nk + 4'd6;
  end

  // round key memory, one 128-bit round key per row; one 32-bit word written per cycle
  // in the key schedule, one row read per cycle into a register for the rounds
  logic [127:0] rk_mem [actr_pkg::RkRows];

  actr_pkg::state_t state_r, state_nxt;
  logic [IdxW-1:0]  widx_r, widx_nxt;     // next key word to generate
  logic [3:0]       rnd_r, rnd_nxt;
  logic [3:0]       ic_r, ic_nxt;         // i mod nk
  logic [7:0]       rcon_r, rcon_nxt;
  logic [255:0]     win_r, win_nxt;       // last nk key words, word 0 oldest
  logic [127:0]     blk_r, blk_nxt;
  logic [63:0]      off_r, off_nxt;
  logic [127:0]     dat_r;
  logic [4:0]       cnt_r;
  logic             last_r;
  logic             ov_r, ov_nxt;
  logic [127:0]     res_r;
  logic [4:0]       ocnt_r;
  logic             olast_r;

  logic         acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;

  // key word generator
  logic [31:0] wprev, wold, tw, wnew;
  logic [IdxW-1:0] total;
  always_comb begin
    wprev = win_r[32*(nk-1) +: 32];
    wold  = win_r[31:0];
    tw    = wprev;
    if (ic_r == 4'd0) begin
      tw = {actr_pkg::sbox(wprev[7:0]), actr_pkg::sbox(wprev[31:24]),
            actr_pkg::sbox(wprev[23:16]), actr_pkg::sbox(wprev[15:8]) ^ rcon_r};
    end else if (nk == 4'd8 && ic_r == 4'd4) begin
      tw = {actr_pkg::sbox(wprev[31:24]), actr_pkg::sbox(wprev[23:16]),
            actr_pkg::sbox(wprev[15:8]), actr_pkg::sbox(wprev[7:0])};
    end
    wnew  = wold ^ tw;
    total = IdxW'({nr, 2'b00} + 6'd4);
  end

  // shared round unit, round key from the registered memory read
  logic [127:0] rkey_r, rnd_out;

  actr_round u_round (
    .state_i (blk_r),
    .final_i (rnd_r == nr),
    .rkey_i  (rkey_r),
    .state_o (rnd_out)
  );

  // memory write and read
  always_ff @(posedge clk) begin
    if (state_r == actr_pkg::ST_KEY && widx_r < total) begin
      rk_mem[widx_r[5:2]][32*widx_r[1:0] +: 32] <= wnew;
    end else if (acc_in) begin
      // raw key words; words past nk are overwritten by the schedule
      rk_mem[4'd0] <= {key_r[1], key_r[0]};
      rk_mem[4'd1] <= {key_r[3], key_r[2]};
    end
    if (state_nxt == actr_pkg::ST_RND) rkey_r <= rk_mem[rnd_nxt];
  end

  // keystream xor with byte masking
  logic [127:0] res_c;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      res_c[8*i +: 8] = (5'(i) < cnt_r) ? (dat_r[8*i +: 8] ^ blk_r[8*i +: 8]) : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    rnd_nxt   = rnd_r;
    ic_nxt    = ic_r;
    rcon_nxt  = rcon_r;
    win_nxt   = win_r;
    blk_nxt   = blk_r;
    off_nxt   = off_r;
    ov_nxt    = ov_r;
    unique case (state_r)
      actr_pkg::ST_IDLE: begin
        if (acc_in) begin
          state_nxt = actr_pkg::ST_KEY;
          widx_nxt  = IdxW'(nk);
          ic_nxt    = '0;
          rcon_nxt  = 8'h01;
          win_nxt   = {key_r[3], key_r[2], key_r[1], key_r[0]};
          if (in_begin_req) off_nxt = in_start_offset;
        end
      end
      actr_pkg::ST_KEY: begin
        if (widx_r < total) begin
          widx_nxt = widx_r + IdxW'(1);
          win_nxt  = win_r;
          for (int k = 0; k < 7; k++) begin
            if (4'(k) < nk - 4'd1) win_nxt[32*k +: 32] = win_r[32*(k+1) +: 32];
          end
          win_nxt[32*(nk-1) +: 32] = wnew;
          if (ic_r == nk - 4'd1) begin
            ic_nxt = '0;
          end else begin
            ic_nxt = ic_r + 4'd1;
          end
          if (ic_r == 4'd0) rcon_nxt = actr_pkg::xtime(rcon_r);
        end else begin
          // initial whitening with round key 0, which is the first key half
          blk_nxt = {off_r, nonce_r} ^ {key_r[1], key_r[0]};
          rnd_nxt = 4'd1;
          state_nxt = actr_pkg::ST_RND;
        end
      end
      actr_pkg::ST_RND: begin
        blk_nxt = rnd_out;
        if (rnd_r == nr) begin
          state_nxt = actr_pkg::ST_OUT;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      actr_pkg::ST_OUT: begin
        if (!ov_r) begin
          ov_nxt    = 1'b1;
          off_nxt   = off_r + 64'(cnt_r);
          state_nxt = actr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = actr_pkg::ST_IDLE;
    endcase
    if (out_ch.valid && out_ch.ready && state_r != actr_pkg::ST_OUT) ov_nxt = 1'b0;
    if (out_ch.valid && out_ch.ready && state_r == actr_pkg::ST_OUT) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= actr_pkg::ST_IDLE;
      off_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r <= widx_nxt;
    rnd_r  <= rnd_nxt;
    ic_r   <= ic_nxt;
    rcon_r <= rcon_nxt;
    win_r  <= win_nxt;
    blk_r  <= blk_nxt;
    if (acc_in) begin
      dat_r  <= {in_data_hi, in_data_lo};
      cnt_r  <= (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;
      last_r <= in_last_in;
    end
    if (state_r == actr_pkg::ST_OUT && !ov_r) begin
      res_r   <= res_c;
      ocnt_r  <= cnt_r;
      olast_r <= last_r;
    end
  end

  assign in_ch.ready    = (state_r == actr_pkg::ST_IDLE);
  assign out_ch.valid   = ov_r;
  assign out_ch.payload = {res_r[63:0], res_r[127:64], ocnt_r, olast_r};

  // a waiting result holds still until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.payload)))
    else $error("result dropped or changed while waiting");

  // an accepted request always starts the key schedule
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> (state_r == actr_pkg::ST_KEY))
    else $error("request not started");

  // offset only moves on completion or a new request
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == actr_pkg::ST_RND) |=> $stable(off_r))
    else $error("offset changed mid block");

endmodule
`default_nettype wire
